[rtl/ims_pkg.sv]
// Shared constants, types and helper functions of the interference matrix builder.
`default_nettype none

package ims_pkg;

  // Number of architectural registers tracked (2 to 64).
  localparam int NUM_REGS = 64;

  // Fixed field widths.
  localparam int REG_W  = 64;
  localparam int IDX_W  = 6;
  localparam int MODE_W = 2;
  localparam int ROWS   = 64;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSTR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  typedef logic [REG_W-1:0] reg_set_t;

  // One processed item as seen by the state-holding units.
  typedef struct packed {
    logic              en;
    logic [MODE_W-1:0] mode;
    reg_set_t          live_out;
    reg_set_t          dst;
    reg_set_t          src;
    logic [IDX_W-1:0]  idx;
  } ims_op_t;

  // Mask of the registers that exist.
  function automatic reg_set_t reg_mask_f();
    reg_set_t m;
    for (int i = 0; i < REG_W; i++) begin
      m[i] = (i < NUM_REGS);
    end
    return m;
  endfunction

  localparam reg_set_t REG_MASK = reg_mask_f();

  // Mask of all columns strictly below column r.
  function automatic reg_set_t below_f(input logic [IDX_W-1:0] r);
    reg_set_t b;
    for (int i = 0; i < REG_W; i++) begin
      b[i] = (IDX_W'(i) < r);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/ims_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface ims_in_if import ims_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  reg_set_t          live_out_bits;
  reg_set_t          dest_mask;
  reg_set_t          src_mask;
  logic [IDX_W-1:0]  row_index;

  modport source (output valid, mode, live_out_bits, dest_mask, src_mask, row_index,
                  input ready);
  modport sink   (input valid, mode, live_out_bits, dest_mask, src_mask, row_index,
                  output ready);
endinterface

interface ims_out_if import ims_pkg::*; ();
  logic     valid;
  logic     ready;
  reg_set_t row_bits;
  reg_set_t live_now;

  modport source (output valid, row_bits, live_now, input ready);
  modport sink   (input valid, row_bits, live_now, output ready);
endinterface

`default_nettype wire

[rtl/ims_live.sv]
// Live register set tracker.
`default_nettype none

module ims_live import ims_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire ims_op_t op,
  output reg_set_t     live_cur,
  output reg_set_t     live_nxt
);

  reg_set_t live_r;

  // Next live set: load, or kill the destinations and add the sources; other modes keep it.
  always_comb begin
    live_nxt = live_r;
    case (op.mode)
      MODE_LOAD:  live_nxt = op.live_out & REG_MASK;
      MODE_INSTR: live_nxt = ((live_r & ~op.dst) | op.src) & REG_MASK;
      MODE_READ:  live_nxt = live_r;
      MODE_CLEAR: live_nxt = live_r;
      default:    live_nxt = live_r;
    endcase
  end

  // The live set changes only when a transaction is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (op.en) begin
      live_r <= live_nxt;
    end
  end

  assign live_cur = live_r;

endmodule

`default_nettype wire

[rtl/ims_matrix.sv]
// Lower-triangular interference bit matrix with parallel row update and one row read.
`default_nettype none

module ims_matrix import ims_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ims_op_t  op,
  input  wire reg_set_t live,
  output reg_set_t      row_bits
);

  reg_set_t rows_r   [ROWS];
  reg_set_t rows_nxt [ROWS];

  // Each row gathers new edges from the destinations and the live set; a clear empties it.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      rows_nxt[r] = rows_r[r];
      case (op.mode)
        MODE_INSTR: begin
          rows_nxt[r] = rows_r[r]
                      | ((op.dst[r] ? live : '0) & below_f(IDX_W'(r)))
                      | ((live[r] ? op.dst : '0) & below_f(IDX_W'(r)));
        end
        MODE_CLEAR: rows_nxt[r] = '0;
        MODE_LOAD:  rows_nxt[r] = rows_r[r];
        MODE_READ:  rows_nxt[r] = rows_r[r];
        default:    rows_nxt[r] = rows_r[r];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      if (!rst_n) begin
        rows_r[r] <= '0;
      end else if (op.en) begin
        rows_r[r] <= rows_nxt[r];
      end
    end
  end

  // Row read; rows beyond the register count read as zero, other modes give zero.
  always_comb begin
    row_bits = '0;
    if (op.mode == MODE_READ && {1'b0, op.idx} < (IDX_W+1)'(NUM_REGS)) begin
      row_bits = rows_r[op.idx] & below_f(op.idx);
    end
  end

endmodule

`default_nettype wire

[rtl/interference_matrix_builder.sv]
// Top level of the register interference matrix builder.
// Usage: instructions of a basic block are sent in reverse program order on the
// input channel (in_ch). A load item (mode 0) sets the live-out set, an
// instruction item (mode 1) records interference of its destinations with the
// live set and updates liveness, a read item (mode 2) returns one matrix row
// and a clear item (mode 3) empties the matrix. Every item gives exactly one
// result transaction on out_ch with the row bits and the live set after it.
// Pipeline: a transaction accepted on in_ch passes through two stored stages,
// an input register and then a result register that presents it on out_ch.
// Throughput is one item per cycle while the receiver does not stall; all 64
// matrix rows update in parallel in the cycle an item passes from the input
// register to the result register.
// When the receiver stalls, the result register holds its transaction and the
// input register takes one more; in_ch.ready falls only while both are full.
// Reset (rst_n low, synchronous) empties both registers, clears the matrix and
// the live set.
`default_nettype none

module interference_matrix_builder import ims_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ims_in_if.sink    in_ch,
  ims_out_if.source out_ch
);

  // Input register.
  logic              in_valid_r;
  logic [MODE_W-1:0] in_mode_r;
  reg_set_t          in_live_out_r;
  reg_set_t          in_dst_r;
  reg_set_t          in_src_r;
  logic [IDX_W-1:0]  in_idx_r;

  // Result register.
  logic     out_valid_r;
  reg_set_t out_row_r;
  reg_set_t out_live_r;

  logic     adv;
  ims_op_t  op;
  reg_set_t live_cur;
  reg_set_t live_nxt;
  reg_set_t row_bits;

  // The input register moves on when the result register is free or being taken.
  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_mode_r     <= in_ch.mode;
      in_live_out_r <= in_ch.live_out_bits;
      in_dst_r      <= in_ch.dest_mask;
      in_src_r      <= in_ch.src_mask;
      in_idx_r      <= in_ch.row_index;
    end
  end

  // Operation handed to the state units; register bits beyond the count are dropped.
  always_comb begin
    op.en       = adv;
    op.mode     = in_mode_r;
    op.live_out = in_live_out_r & REG_MASK;
    op.dst      = in_dst_r & REG_MASK;
    op.src      = in_src_r & REG_MASK;
    op.idx      = in_idx_r;
  end

  ims_live u_live (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .live_cur (live_cur),
    .live_nxt (live_nxt)
  );

  ims_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .live     (live_cur),
    .row_bits (row_bits)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_r  <= row_bits;
      out_live_r <= live_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.row_bits = out_row_r;
  assign out_ch.live_now = out_live_r;

endmodule

`default_nettype wire
